@@ sv/cia_pkg.sv @@
// Package for the circle intersection area unit: widths, field types and
// the arctangent table. No dependencies.
`default_nettype none
package cia_pkg;
	localparam int CoordW = 24;
	localparam int RadW   = 23;
	localparam int AreaW  = 36;
	localparam int Steps  = 30;
	localparam logic [31:0] PiQ30 = 32'hC90FDAA2;

	typedef enum logic [1:0] {
		CASE_LENS     = 2'd0,
		CASE_CONTAIN  = 2'd1,
		CASE_DISJOINT = 2'd2
	} case_t;

	typedef struct packed {
		logic signed [CoordW-1:0] first_x;
		logic signed [CoordW-1:0] first_y;
		logic [RadW-1:0]          first_radius;
		logic signed [CoordW-1:0] second_x;
		logic signed [CoordW-1:0] second_y;
		logic [RadW-1:0]          second_radius;
	} in_word_t;

	typedef struct packed {
		logic [AreaW-1:0] overlap_area;
		logic [1:0]       overlap_case;
	} out_word_t;

	// atan(2^-i) rounded to Q30
	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0:  r = 32'd843314857;
			5'd1:  r = 32'd497837829;
			5'd2:  r = 32'd263043837;
			5'd3:  r = 32'd133525159;
			5'd4:  r = 32'd67021687;
			5'd5:  r = 32'd33543516;
			5'd6:  r = 32'd16775851;
			5'd7:  r = 32'd8388437;
			5'd8:  r = 32'd4194283;
			5'd9:  r = 32'd2097149;
			5'd10: r = 32'd1048576;
			5'd11: r = 32'd524288;
			5'd12: r = 32'd262144;
			5'd13: r = 32'd131072;
			5'd14: r = 32'd65536;
			5'd15: r = 32'd32768;
			5'd16: r = 32'd16384;
			5'd17: r = 32'd8192;
			5'd18: r = 32'd4096;
			5'd19: r = 32'd2048;
			5'd20: r = 32'd1024;
			5'd21: r = 32'd512;
			5'd22: r = 32'd256;
			5'd23: r = 32'd128;
			5'd24: r = 32'd64;
			5'd25: r = 32'd32;
			5'd26: r = 32'd16;
			5'd27: r = 32'd8;
			5'd28: r = 32'd4;
			5'd29: r = 32'd2;
			default: r = 32'd0;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

@@ sv/cia_if.sv @@
// Valid/ready channel interface carrying one payload word.
// Depends on nothing; the payload type is a parameter.
`default_nettype none
interface cia_if #(parameter type word_t = logic) ();
	logic  valid;
	logic  ready;
	word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ sv/circle_intersection_area_unit.sv @@
// Circle-circle overlap area: fully pipelined, one word per cycle.
// Pipeline: 134 register stages (square roots, a 30-step divider pair and a
// 30-step CORDIC pair, one step per stage).
// Throughput: one word per cycle; a stall at the output freezes the whole pipe.
// Reset: arst_n clears all stage valid bits; payload registers are not reset.
`default_nettype none
module circle_intersection_area_unit #(
	parameter int FRAC_BITS = 12
) (
	input  wire logic clk,
	input  wire logic arst_n,
	cia_if.sink       in_ch,
	cia_if.source     out_ch
);
	import cia_pkg::*;

	localparam int Sh = 30 + FRAC_BITS;
	// sqrt of d2<<14 : d2 < 2^50, so radicand < 2^64, 32 result bits
	localparam int SqN = 32;
	localparam int DivN = 31;
	localparam int CorN = Steps;
	// stage counts
	localparam int NS = 2 + SqN + 2 + DivN + SqN + 1 + CorN + 4;

	// One flat record carried by every stage; unused fields ride along.
	typedef struct packed {
		logic [45:0]  ra2;
		logic [45:0]  rb2;
		logic [1:0]   kind;
		logic [35:0]  carea;   // containment area
		// sqrt d
		logic [63:0]  sq_rem;
		logic [63:0]  sq_res;
		logic [63:0]  sq_n;
		logic [50:0]  d2;
		// cosines
		logic         na, nb;
		logic [63:0]  ma, mb;  // remainders
		logic [63:0]  da, db;  // denominators
		logic [30:0]  qa, qb;
		logic         sata, satb, za, zb;
		// cordic
		logic signed [33:0] xa, ya, xb, yb;
		logic signed [33:0] za_ang, zb_ang;
		logic [30:0]  sa, sb;  // sqrt(1-c^2)
	} st_t;

	st_t  p   [NS+1];
	logic v   [NS+1];
	logic adv;
	assign adv = !v[NS] || out_ch.ready;
	assign in_ch.ready = adv;

	// stage 0 (combinational entry): geometry
	st_t e;
	logic signed [24:0] dx, dy;
	logic [49:0] dd;
	logic [22:0] ra, rb, rm;
	logic [23:0] rdiff, rsum;
	logic [47:0] diff2, sum2;
	always_comb begin
		e = '0;
		ra = in_ch.data.first_radius;
		rb = in_ch.data.second_radius;
		dx = 25'(in_ch.data.second_x) - 25'(in_ch.data.first_x);
		dy = 25'(in_ch.data.second_y) - 25'(in_ch.data.first_y);
		dd = 50'(dx * dx);
		e.d2 = 51'(dd) + 51'(50'(dy * dy));
		e.ra2 = 46'(ra * ra);
		e.rb2 = 46'(rb * rb);
		rdiff = (ra > rb) ? 24'(ra - rb) : 24'(rb - ra);
		rsum = 24'(ra) + 24'(rb);
		diff2 = 48'(rdiff * rdiff);
		sum2 = 48'(rsum * rsum);
		rm = (ra < rb) ? ra : rb;
		e.carea = 36'(rm);   // squared and scaled over the first stages
		if (e.d2 <= 51'(diff2)) e.kind = CASE_CONTAIN;
		else if (e.d2 >= 51'(sum2)) e.kind = CASE_DISJOINT;
		else e.kind = CASE_LENS;
		e.sq_n = 64'(e.d2) << 14;
		e.sq_rem = e.sq_n;
		e.sq_res = '0;
	end

	// radii carried alongside (needed at the cosine setup stage)
	logic [22:0] rad_a_s [NS+1];
	logic [22:0] rad_b_s [NS+1];

	// per-stage combinational work
	st_t nx [NS];
	localparam int S_SQ  = 1;
	localparam int S_COS = S_SQ + SqN;       // set up cosine dividers
	localparam int S_DIV = S_COS + 2;
	localparam int S_SQC = S_DIV + DivN;     // sqrt(1-c^2)
	localparam int S_SIN = S_SQC + SqN;
	localparam int S_COR = S_SIN + 1;
	localparam int S_FIN = S_COR + CorN;

	for (genvar k = 0; k < NS; k++) begin : g_stage
		always_comb begin
			logic [63:0] bt, tr;
			logic [127:0] pr;
			logic [4:0] ci;
			logic signed [33:0] xs, ys, ta;
			logic signed [63:0] cs;
			logic signed [33:0] g;
			logic [63:0] sa2, sb2;
			logic neg;
			nx[k] = p[k];
			bt = '0; tr = '0; pr = '0; ci = '0; xs = '0; ys = '0; ta = '0;
			cs = '0; g = '0; sa2 = '0; sb2 = '0; neg = 1'b0;
			if (k == 0) begin
				// containment area, first step: square of the smaller radius
				nx[k].ma = 64'(p[k].carea[22:0]) * 64'(p[k].carea[22:0]);
			end else if (k >= S_SQ && k < S_SQ + SqN) begin
				// one result bit of isqrt(sq_n)
				bt = 64'(1) << (2 * (SqN - 1 - (k - S_SQ)));
				tr = p[k].sq_res + bt;
				if (p[k].sq_rem >= tr) begin
					nx[k].sq_rem = p[k].sq_rem - tr;
					nx[k].sq_res = (p[k].sq_res >> 1) + bt;
				end else begin
					nx[k].sq_res = p[k].sq_res >> 1;
				end
			end else if (k == S_COS) begin
				// numerators and denominators: den = 2*dq*r
				nx[k].da = (64'(p[k].sq_res[31:0]) * 64'(rad_a_s[k])) << 1;
				nx[k].db = (64'(p[k].sq_res[31:0]) * 64'(rad_b_s[k])) << 1;
			end else if (k == S_COS + 1) begin
				cs = 64'(p[k].d2) + 64'(p[k].ra2) - 64'(p[k].rb2);
				nx[k].na = cs[63];
				nx[k].ma = (cs[63] ? 64'(-cs) : 64'(cs)) << 7;
				cs = 64'(p[k].d2) - 64'(p[k].ra2) + 64'(p[k].rb2);
				nx[k].nb = cs[63];
				nx[k].mb = (cs[63] ? 64'(-cs) : 64'(cs)) << 7;
				nx[k].za = (p[k].da == 0);
				nx[k].zb = (p[k].db == 0);
				nx[k].sata = (nx[k].ma >= p[k].da);
				nx[k].satb = (nx[k].mb >= p[k].db);
				nx[k].qa = '0;
				nx[k].qb = '0;
			end else if (k >= S_DIV && k < S_DIV + DivN) begin
				if (k == S_DIV + DivN - 1) begin
					// finalize to Q30 magnitude
					if (p[k].za) nx[k].qa = '0;
					else if (p[k].sata) nx[k].qa = 31'h40000000;
					if (p[k].zb) nx[k].qb = '0;
					else if (p[k].satb) nx[k].qb = 31'h40000000;
					sa2 = 64'(1) << 60;
					sa2 = sa2 - 64'(nx[k].qa) * 64'(nx[k].qa);
					sb2 = 64'(1) << 60;
					sb2 = sb2 - 64'(nx[k].qb) * 64'(nx[k].qb);
					nx[k].ma = sa2; nx[k].da = '0;
					nx[k].mb = sb2; nx[k].db = '0;
				end else begin
					if (!p[k].sata && !p[k].za) begin
						nx[k].ma = p[k].ma << 1;
						nx[k].qa = p[k].qa << 1;
						if ((p[k].ma << 1) >= p[k].da) begin
							nx[k].ma = (p[k].ma << 1) - p[k].da;
							nx[k].qa[0] = 1'b1;
						end
					end
					if (!p[k].satb && !p[k].zb) begin
						nx[k].mb = p[k].mb << 1;
						nx[k].qb = p[k].qb << 1;
						if ((p[k].mb << 1) >= p[k].db) begin
							nx[k].mb = (p[k].mb << 1) - p[k].db;
							nx[k].qb[0] = 1'b1;
						end
					end
				end
			end else if (k >= S_SQC && k < S_SQC + SqN) begin
				// isqrt of 1 - c^2 for both cosines (remainder in ma/mb, root in da/db)
				bt = 64'(1) << (2 * (SqN - 1 - (k - S_SQC)));
				tr = p[k].da + bt;
				if (p[k].ma >= tr) begin
					nx[k].ma = p[k].ma - tr;
					nx[k].da = (p[k].da >> 1) + bt;
				end else nx[k].da = p[k].da >> 1;
				tr = p[k].db + bt;
				if (p[k].mb >= tr) begin
					nx[k].mb = p[k].mb - tr;
					nx[k].db = (p[k].db >> 1) + bt;
				end else nx[k].db = p[k].db >> 1;
			end else if (k == S_SIN) begin
				nx[k].sa = 31'(p[k].da);
				nx[k].sb = 31'(p[k].db);
				nx[k].xa = 34'(p[k].qa);
				nx[k].ya = 34'(p[k].da);
				nx[k].xb = 34'(p[k].qb);
				nx[k].yb = 34'(p[k].db);
				nx[k].za_ang = '0;
				nx[k].zb_ang = '0;
			end else if (k >= S_COR && k < S_COR + CorN) begin
				ci = 5'(k - S_COR);
				ta = 34'(atan_q30(ci));
				xs = p[k].xa >>> ci; ys = p[k].ya >>> ci;
				if (!p[k].ya[33]) begin
					nx[k].xa = p[k].xa + ys; nx[k].ya = p[k].ya - xs;
					nx[k].za_ang = p[k].za_ang + ta;
				end else begin
					nx[k].xa = p[k].xa - ys; nx[k].ya = p[k].ya + xs;
					nx[k].za_ang = p[k].za_ang - ta;
				end
				xs = p[k].xb >>> ci; ys = p[k].yb >>> ci;
				if (!p[k].yb[33]) begin
					nx[k].xb = p[k].xb + ys; nx[k].yb = p[k].yb - xs;
					nx[k].zb_ang = p[k].zb_ang + ta;
				end else begin
					nx[k].xb = p[k].xb - ys; nx[k].yb = p[k].yb + xs;
					nx[k].zb_ang = p[k].zb_ang - ta;
				end
			end else if (k == S_FIN) begin
				// g = theta - round(c*s), floored at zero; kept in za_ang / zb_ang
				// a zero cosine counts as positive; a negative one rounds half down
				neg = p[k].na && (p[k].qa != '0);
				cs = (64'(p[k].qa) * 64'(p[k].sa) + (64'(1) << 29) - 64'(neg)) >>> 30;
				if (neg) g = 34'(PiQ30) - p[k].za_ang + 34'(cs);
				else g = p[k].za_ang - 34'(cs);
				nx[k].za_ang = g[33] ? '0 : g;
				neg = p[k].nb && (p[k].qb != '0);
				cs = (64'(p[k].qb) * 64'(p[k].sb) + (64'(1) << 29) - 64'(neg)) >>> 30;
				if (neg) g = 34'(PiQ30) - p[k].zb_ang + 34'(cs);
				else g = p[k].zb_ang - 34'(cs);
				nx[k].zb_ang = g[33] ? '0 : g;
			end else if (k == S_FIN + 1) begin
				// segment products as low and high partials of r^2
				nx[k].ma = 64'(p[k].ra2[22:0]) * 64'(p[k].za_ang[31:0]);
				nx[k].da = 64'(p[k].ra2[45:23]) * 64'(p[k].za_ang[31:0]);
				nx[k].mb = 64'(p[k].rb2[22:0]) * 64'(p[k].zb_ang[31:0]);
				nx[k].db = 64'(p[k].rb2[45:23]) * 64'(p[k].zb_ang[31:0]);
			end else if (k == S_FIN + 2) begin
				pr = (128'(p[k].da) << 23) + 128'(p[k].ma) + (128'(1) << (Sh - 1));
				nx[k].ma = 64'(pr >> Sh);
				pr = (128'(p[k].db) << 23) + 128'(p[k].mb) + (128'(1) << (Sh - 1));
				nx[k].mb = 64'(pr >> Sh);
			end else if (k == S_FIN + 3) begin
				tr = p[k].ma + p[k].mb;
				case (p[k].kind)
					CASE_CONTAIN:  nx[k].carea = p[k].carea;
					CASE_DISJOINT: nx[k].carea = '0;
					default:
						nx[k].carea = (tr > 64'(36'hFFFFFFFFF)) ? 36'hFFFFFFFFF : 36'(tr);
				endcase
			end
			if (k == 1) begin
				// containment area: times pi as two 23x32 partials
				nx[k].ma = 64'(p[k].ma[22:0]) * 64'(PiQ30);
				nx[k].mb = 64'(p[k].ma[45:23]) * 64'(PiQ30);
			end
			if (k == 2) begin
				pr = (128'(p[k].mb) << 23) + 128'(p[k].ma) + (128'(1) << (Sh - 1));
				pr = pr >> Sh;
				nx[k].carea = (pr > 128'(36'hFFFFFFFFF)) ? 36'hFFFFFFFFF : 36'(pr);
			end
		end
	end

	for (genvar k = 1; k <= NS; k++) begin : g_reg
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v[k] <= 1'b0;
			end else if (adv) begin
				v[k] <= v[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				p[k] <= nx[k-1];
				rad_a_s[k] <= rad_a_s[k-1];
				rad_b_s[k] <= rad_b_s[k-1];
			end
		end
	end

	always_comb begin
		p[0] = e;
		v[0] = in_ch.valid;
		rad_a_s[0] = in_ch.data.first_radius;
		rad_b_s[0] = in_ch.data.second_radius;
	end

	assign out_ch.valid = v[NS];
	assign out_ch.data.overlap_area = p[NS].carea;
	assign out_ch.data.overlap_case = p[NS].kind;
endmodule
`default_nettype wire

@@ sv/cia_checker.sv @@
// Port-level checker for the circle intersection area unit, bound to the
// top level. Depends on cia_pkg.
`default_nettype none
module cia_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [35:0] area,
	input wire logic [1:0]  kind
);
	import cia_pkg::*;
	a_case: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (kind == CASE_LENS || kind == CASE_CONTAIN || kind == CASE_DISJOINT))
		else $error("bad case code");
	a_disj: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == CASE_DISJOINT |-> area == '0)
		else $error("disjoint word with area");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(area) && $stable(kind))
		else $error("stalled word changed");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input blocked while output drains");
endmodule

bind circle_intersection_area_unit cia_checker u_cia_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.area(out_ch.data.overlap_area), .kind(out_ch.data.overlap_case)
);
`default_nettype wire
